// File: rtl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    localparam int MIN_ORDER      = 6;
    localparam int MAX_ORDER      = 16;
    localparam int HEAP_ADDR_BITS = 20;
    localparam int HEADER_BYTES   = 16;

    localparam int NUM_ORDERS = MAX_ORDER - MIN_ORDER + 1;
    localparam int SLOT_BITS  = HEAP_ADDR_BITS - MIN_ORDER;
    localparam int NUM_SLOTS  = 1 << SLOT_BITS;
    localparam int LINK_BITS  = SLOT_BITS + 1;
    localparam int ORD_BITS   = 6;
    localparam int OU_BITS    = ORD_BITS + 1;
    localparam int KIDX_BITS  = $clog2(NUM_ORDERS);

    localparam int ADDR_W     = 48;
    localparam int LEN_W      = 24;
    localparam int TOT_W      = 21;
    localparam int HB_W       = 21;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [LINK_BITS-1:0] t_link;
    typedef logic [ORD_BITS-1:0]  t_ord;
    typedef logic [KIDX_BITS-1:0] t_kidx;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_BYTES = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RS_OK        = 2'd0,
        RS_TOO_LARGE = 2'd1,
        RS_NO_MEM    = 2'd2
    } t_rsp_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_UNLINK,
        ST_SPLIT,
        ST_FCHECK,
        ST_BREAD,
        ST_BCHECK,
        ST_BZERO,
        ST_PUSH,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_FIND,
        DP_UNLINK,
        DP_SPLIT,
        DP_ACOMMIT,
        DP_FREAD,
        DP_FCHECK,
        DP_BREAD,
        DP_BUNLINK,
        DP_BZERO,
        DP_PUSH,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic addr_zero;
        logic too_large;
        logic found;
        logic can_carve;
        logic split_more;
        logic ord_bad;
        logic at_max;
        logic merge_ok;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic too_large;
        t_ord ord;
    } t_size;

    function automatic t_slot link_to_slot(t_link l);
        t_link d;
        d = l - t_link'(1);
        return d[SLOT_BITS-1:0];
    endfunction

    function automatic t_link slot_to_link(t_slot s);
        return t_link'(s) + t_link'(1);
    endfunction

    function automatic t_kidx ord_to_kidx(t_ord o);
        t_ord d;
        d = o - t_ord'(MIN_ORDER);
        return d[KIDX_BITS-1:0];
    endfunction

    function automatic logic [TOT_W-1:0] block_bytes(t_ord o);
        return TOT_W'(1) << o;
    endfunction

    // Smallest order whose block holds the request plus its header.
    function automatic t_size alloc_size(logic [LEN_W-1:0] len);
        t_size r;
        r.too_large = 1'b1;
        r.ord       = t_ord'(MAX_ORDER);
        for (int k = MAX_ORDER; k >= MIN_ORDER; k--) begin
            if (64'(len) <= (64'd1 << k) - 64'(HEADER_BYTES)) begin
                r.too_large = 1'b0;
                r.ord       = t_ord'(k);
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/bba_req_if.sv
`timescale 1ns / 1ps

interface bba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [bba_pkg::LEN_W-1:0]    length;
    logic [bba_pkg::ADDR_W-1:0]   address;

    modport source (output valid, req_type, length, address, input ready);
    modport sink   (input valid, req_type, length, address, output ready);
endinterface

// File: rtl/bba_rsp_if.sv
`timescale 1ns / 1ps

interface bba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bba_pkg::ADDR_W-1:0]   address_out;
    logic [1:0]                   status;
    logic [bba_pkg::TOT_W-1:0]    allocated_bytes;

    modport source (output valid, address_out, status, allocated_bytes, input ready);
    modport sink   (input valid, address_out, status, allocated_bytes, output ready);
endinterface

// File: rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps

// Buddy allocator over a heap window of up to 1 MiB, with blocks of 64 B to 64 KiB and
// one header per 64 B slot held in on-chip memory. One request is handled at a time:
// an allocate takes a block from a free list or carves a fresh chunk, splits it down
// one order at a time and commits it; a free checks the block's header, merges it with
// each free buddy of equal order until the largest order, and pushes it onto its free
// list. After the result is emitted the block returns to idle before it accepts the next
// request. The result sits in an output register, so the next request is accepted while
// it waits to be taken. Headers need no clearing after reset; configuration must be
// written only while the block is idle, which the block itself does not enforce.
module buddy_block_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bba_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    bba_req_if.sink                          i_req,
    bba_rsp_if.source                        o_rsp
);

    bba_pkg::t_dp_cmd  cmd;
    bba_pkg::t_dp_stat stat;
    logic              in_ready;
    logic [1:0]        status;

    assign i_req.ready = in_ready;
    assign o_rsp.status = status;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    bba_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_type        (i_req.req_type),
        .i_length          (i_req.length),
        .i_address         (i_req.address),
        .o_out_valid       (o_rsp.valid),
        .i_out_ready       (o_rsp.ready),
        .o_address_out     (o_rsp.address_out),
        .o_status          (status),
        .o_allocated_bytes (o_rsp.allocated_bytes)
    );

endmodule

// File: rtl/bba_datapath.sv
`timescale 1ns / 1ps

module bba_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bba_pkg::t_dp_cmd                 i_cmd,
    output bba_pkg::t_dp_stat                o_stat,
    input  logic                             i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bba_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_req_type,
    input  logic [bba_pkg::LEN_W-1:0]        i_length,
    input  logic [bba_pkg::ADDR_W-1:0]       i_address,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bba_pkg::ADDR_W-1:0]       o_address_out,
    output logic [1:0]                       o_status,
    output logic [bba_pkg::TOT_W-1:0]        o_allocated_bytes
);

    // Header store, split by field so one field can be written without a read.
    bba_pkg::t_link                     mem_prev [bba_pkg::NUM_SLOTS];
    bba_pkg::t_link                     mem_next [bba_pkg::NUM_SLOTS];
    logic [bba_pkg::OU_BITS-1:0]        mem_ou   [bba_pkg::NUM_SLOTS];

    bba_pkg::t_link                     r_rd_prev;
    bba_pkg::t_link                     r_rd_next;
    bba_pkg::t_ord                      r_rd_ord;
    logic                               r_rd_used;

    bba_pkg::t_link                     r_heads [bba_pkg::NUM_ORDERS];
    logic [bba_pkg::TOT_W-1:0]          r_carve;
    logic [bba_pkg::TOT_W-1:0]          r_total;
    logic [bba_pkg::ADDR_W-1:0]         r_base;
    logic [bba_pkg::HB_W-1:0]           r_hbytes;
    logic                               r_out_valid;

    logic                               r_is_free;
    logic                               r_addr_zero;
    logic                               r_too_large;
    bba_pkg::t_ord                      r_ord;
    bba_pkg::t_ord                      r_j;
    bba_pkg::t_ord                      r_hord;
    bba_pkg::t_slot                     r_s;
    bba_pkg::t_slot                     r_b;
    bba_pkg::t_rsp_status               r_status;
    logic [bba_pkg::ADDR_W-1:0]         r_res_addr;
    logic [bba_pkg::ADDR_W-1:0]         r_out_addr;
    bba_pkg::t_rsp_status               r_out_status;
    logic [bba_pkg::TOT_W-1:0]          r_out_total;

    logic                               prev_we, next_we, ou_we, rd_en;
    bba_pkg::t_slot                     prev_addr, next_addr, ou_addr, rd_addr;
    bba_pkg::t_link                     prev_data, next_data;
    logic [bba_pkg::OU_BITS-1:0]        ou_data;

    bba_pkg::t_size                     load_size;
    logic [bba_pkg::ADDR_W-1:0]         load_rel;
    logic                               found;
    bba_pkg::t_kidx                     found_k;
    logic [bba_pkg::TOT_W:0]            carve_end;
    logic                               can_carve;
    bba_pkg::t_ord                      split_ord;
    bba_pkg::t_slot                     split_t;
    bba_pkg::t_slot                     buddy;
    bba_pkg::t_slot                     merged_s;
    bba_pkg::t_ord                      next_ord;
    bba_pkg::t_link                     head_k;
    logic                               ord_bad;
    logic                               out_free;

    assign load_size = bba_pkg::alloc_size(i_length);
    assign load_rel  = i_address - bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES) - r_base;

    always_comb begin
        found   = 1'b0;
        found_k = '0;
        for (int k = bba_pkg::NUM_ORDERS - 1; k >= 0; k--) begin
            if (bba_pkg::KIDX_BITS'(k) >= bba_pkg::ord_to_kidx(r_ord) &&
                r_heads[k] != '0) begin
                found   = 1'b1;
                found_k = bba_pkg::KIDX_BITS'(k);
            end
        end
    end

    assign carve_end = (bba_pkg::TOT_W+1)'(r_carve) +
                       (bba_pkg::TOT_W+1)'(1 << bba_pkg::MAX_ORDER);
    assign can_carve = (carve_end <= (bba_pkg::TOT_W+1)'(r_hbytes)) &&
                       (carve_end <= (bba_pkg::TOT_W+1)'(1 << bba_pkg::HEAP_ADDR_BITS));

    assign split_ord = r_j - bba_pkg::t_ord'(1);
    assign split_t   = r_s + (bba_pkg::t_slot'(1) << bba_pkg::ord_to_kidx(split_ord));
    assign buddy     = r_s ^ (bba_pkg::t_slot'(1) << bba_pkg::ord_to_kidx(r_ord));
    assign merged_s  = (r_b < r_s) ? r_b : r_s;
    assign next_ord  = r_ord + bba_pkg::t_ord'(1);
    assign head_k    = r_heads[bba_pkg::ord_to_kidx(r_ord)];
    assign ord_bad   = (r_rd_ord < bba_pkg::t_ord'(bba_pkg::MIN_ORDER)) ||
                       (r_rd_ord > bba_pkg::t_ord'(bba_pkg::MAX_ORDER));
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.is_free    = r_is_free;
        o_stat.addr_zero  = r_addr_zero;
        o_stat.too_large  = r_too_large;
        o_stat.found      = found;
        o_stat.can_carve  = can_carve;
        o_stat.split_more = r_j > r_ord;
        o_stat.ord_bad    = ord_bad;
        o_stat.at_max     = r_ord == bba_pkg::t_ord'(bba_pkg::MAX_ORDER);
        o_stat.merge_ok   = !r_rd_used && (r_rd_ord == r_ord);
        o_stat.out_free   = out_free;
    end

    // Memory port steering for each datapath operation.
    always_comb begin
        prev_we   = 1'b0;
        next_we   = 1'b0;
        ou_we     = 1'b0;
        rd_en     = 1'b0;
        prev_addr = r_s;
        next_addr = r_s;
        ou_addr   = r_s;
        rd_addr   = r_s;
        prev_data = '0;
        next_data = '0;
        ou_data   = '0;
        case (i_cmd.op)
            bba_pkg::DP_FIND: begin
                rd_en   = found && !r_too_large;
                rd_addr = bba_pkg::link_to_slot(r_heads[found_k]);
            end
            bba_pkg::DP_UNLINK, bba_pkg::DP_BUNLINK: begin
                if (r_rd_next != '0) begin
                    prev_we   = 1'b1;
                    prev_addr = bba_pkg::link_to_slot(r_rd_next);
                    prev_data = r_rd_prev;
                end
                if (r_rd_prev != '0) begin
                    next_we   = 1'b1;
                    next_addr = bba_pkg::link_to_slot(r_rd_prev);
                    next_data = r_rd_next;
                end
            end
            bba_pkg::DP_SPLIT: begin
                prev_we   = 1'b1;
                next_we   = 1'b1;
                ou_we     = 1'b1;
                prev_addr = split_t;
                next_addr = split_t;
                ou_addr   = split_t;
                ou_data   = {split_ord, 1'b0};
            end
            bba_pkg::DP_ACOMMIT: begin
                prev_we = 1'b1;
                next_we = 1'b1;
                ou_we   = 1'b1;
                ou_data = {r_hord, 1'b1};
            end
            bba_pkg::DP_FREAD: begin
                rd_en = 1'b1;
            end
            bba_pkg::DP_FCHECK: begin
                ou_we   = !ord_bad;
                ou_data = {r_rd_ord, 1'b0};
            end
            bba_pkg::DP_BREAD: begin
                rd_en   = 1'b1;
                rd_addr = buddy;
            end
            bba_pkg::DP_BZERO: begin
                prev_we   = 1'b1;
                next_we   = 1'b1;
                ou_we     = 1'b1;
                prev_addr = r_b;
                next_addr = r_b;
                ou_addr   = merged_s;
                ou_data   = {next_ord, 1'b0};
            end
            bba_pkg::DP_PUSH: begin
                next_we   = 1'b1;
                next_data = head_k;
                if (head_k != '0) begin
                    prev_we   = 1'b1;
                    prev_addr = bba_pkg::link_to_slot(head_k);
                    prev_data = bba_pkg::slot_to_link(r_s);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            mem_prev[prev_addr] <= prev_data;
        end
        if (rd_en) begin
            r_rd_prev <= mem_prev[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            mem_next[next_addr] <= next_data;
        end
        if (rd_en) begin
            r_rd_next <= mem_next[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ou_we) begin
            mem_ou[ou_addr] <= ou_data;
        end
        if (rd_en) begin
            {r_rd_ord, r_rd_used} <= mem_ou[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bba_pkg::NUM_ORDERS; k++) begin
                r_heads[k] <= '0;
            end
            r_carve     <= '0;
            r_total     <= '0;
            r_base      <= '0;
            r_hbytes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (bba_pkg::t_cfg_idx'(i_cfg_idx))
                    bba_pkg::CFG_HEAP_BASE:  r_base   <= i_cfg_wdata[bba_pkg::ADDR_W-1:0];
                    bba_pkg::CFG_HEAP_BYTES: r_hbytes <= i_cfg_wdata[bba_pkg::HB_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == bba_pkg::DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                bba_pkg::DP_FIND: begin
                    if (!r_too_large && !found && can_carve) begin
                        r_carve <= carve_end[bba_pkg::TOT_W-1:0];
                    end
                end
                bba_pkg::DP_UNLINK: begin
                    r_heads[bba_pkg::ord_to_kidx(r_j)] <= r_rd_next;
                end
                bba_pkg::DP_SPLIT: begin
                    r_heads[bba_pkg::ord_to_kidx(split_ord)] <= bba_pkg::slot_to_link(split_t);
                end
                bba_pkg::DP_ACOMMIT: begin
                    r_total <= r_total + bba_pkg::block_bytes(r_ord);
                end
                bba_pkg::DP_FCHECK: begin
                    if (!ord_bad) begin
                        r_total <= r_total - bba_pkg::block_bytes(r_rd_ord);
                    end
                end
                bba_pkg::DP_BUNLINK: begin
                    if (head_k == bba_pkg::slot_to_link(r_b)) begin
                        r_heads[bba_pkg::ord_to_kidx(r_ord)] <= r_rd_next;
                    end
                end
                bba_pkg::DP_PUSH: begin
                    r_heads[bba_pkg::ord_to_kidx(r_ord)] <= bba_pkg::slot_to_link(r_s);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_free   <= i_req_type;
            r_addr_zero <= i_address == '0;
            r_too_large <= load_size.too_large;
            r_ord       <= load_size.ord;
            r_s         <= load_rel[bba_pkg::MIN_ORDER +: bba_pkg::SLOT_BITS];
            r_status    <= bba_pkg::RS_OK;
            r_res_addr  <= '0;
        end
        case (i_cmd.op)
            bba_pkg::DP_FIND: begin
                if (r_too_large) begin
                    r_status <= bba_pkg::RS_TOO_LARGE;
                end else if (found) begin
                    r_j <= bba_pkg::t_ord'(bba_pkg::MIN_ORDER) + bba_pkg::t_ord'(found_k);
                    r_s <= bba_pkg::link_to_slot(r_heads[found_k]);
                end else if (can_carve) begin
                    r_j    <= bba_pkg::t_ord'(bba_pkg::MAX_ORDER);
                    r_hord <= bba_pkg::t_ord'(bba_pkg::MAX_ORDER);
                    r_s    <= r_carve[bba_pkg::MIN_ORDER +: bba_pkg::SLOT_BITS];
                end else begin
                    r_status <= bba_pkg::RS_NO_MEM;
                end
            end
            bba_pkg::DP_UNLINK: begin
                r_hord <= r_rd_ord;
            end
            bba_pkg::DP_SPLIT: begin
                r_j    <= split_ord;
                r_hord <= split_ord;
            end
            bba_pkg::DP_ACOMMIT: begin
                r_res_addr <= r_base + (bba_pkg::ADDR_W'(r_s) << bba_pkg::MIN_ORDER) +
                              bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES);
            end
            bba_pkg::DP_FCHECK: begin
                r_ord <= r_rd_ord;
            end
            bba_pkg::DP_BREAD: begin
                r_b <= buddy;
            end
            bba_pkg::DP_BZERO: begin
                r_s   <= merged_s;
                r_ord <= next_ord;
            end
            bba_pkg::DP_EMIT: begin
                r_out_addr   <= r_res_addr;
                r_out_status <= r_status;
                r_out_total  <= r_total;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_address_out     = r_out_addr;
    assign o_status          = r_out_status;
    assign o_allocated_bytes = r_out_total;

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == bba_pkg::DP_EMIT) |-> out_free)
        else $error("result emitted while output register is occupied");

    a_split_above_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == bba_pkg::DP_SPLIT) |-> (r_j > r_ord))
        else $error("split issued at or below the requested order");

    a_commit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == bba_pkg::DP_ACOMMIT) |-> (r_status == bba_pkg::RS_OK))
        else $error("allocation committed with a failure status");

    a_carve_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == bba_pkg::DP_FIND) |=>
            (r_carve <= bba_pkg::TOT_W'(1 << bba_pkg::HEAP_ADDR_BITS)))
        else $error("carve offset ran past the heap address space");

endmodule

// File: rtl/bba_ctrl.sv
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output bba_pkg::t_dp_cmd    o_cmd,
    input  bba_pkg::t_dp_stat   i_stat
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.op   = bba_pkg::DP_NOP;
        case (r_state)
            bba_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bba_pkg::ST_FIND;
                end
            end
            bba_pkg::ST_FIND: begin
                if (i_stat.is_free) begin
                    if (i_stat.addr_zero) begin
                        n_state = bba_pkg::ST_DONE;
                    end else begin
                        o_cmd.op = bba_pkg::DP_FREAD;
                        n_state  = bba_pkg::ST_FCHECK;
                    end
                end else begin
                    o_cmd.op = bba_pkg::DP_FIND;
                    if (i_stat.too_large) begin
                        n_state = bba_pkg::ST_DONE;
                    end else if (i_stat.found) begin
                        n_state = bba_pkg::ST_UNLINK;
                    end else if (i_stat.can_carve) begin
                        n_state = bba_pkg::ST_SPLIT;
                    end else begin
                        n_state = bba_pkg::ST_DONE;
                    end
                end
            end
            bba_pkg::ST_UNLINK: begin
                o_cmd.op = bba_pkg::DP_UNLINK;
                n_state  = bba_pkg::ST_SPLIT;
            end
            bba_pkg::ST_SPLIT: begin
                if (i_stat.split_more) begin
                    o_cmd.op = bba_pkg::DP_SPLIT;
                end else begin
                    o_cmd.op = bba_pkg::DP_ACOMMIT;
                    n_state  = bba_pkg::ST_DONE;
                end
            end
            bba_pkg::ST_FCHECK: begin
                o_cmd.op = bba_pkg::DP_FCHECK;
                n_state  = i_stat.ord_bad ? bba_pkg::ST_DONE : bba_pkg::ST_BREAD;
            end
            bba_pkg::ST_BREAD: begin
                if (i_stat.at_max) begin
                    n_state = bba_pkg::ST_PUSH;
                end else begin
                    o_cmd.op = bba_pkg::DP_BREAD;
                    n_state  = bba_pkg::ST_BCHECK;
                end
            end
            bba_pkg::ST_BCHECK: begin
                if (i_stat.merge_ok) begin
                    o_cmd.op = bba_pkg::DP_BUNLINK;
                    n_state  = bba_pkg::ST_BZERO;
                end else begin
                    n_state = bba_pkg::ST_PUSH;
                end
            end
            bba_pkg::ST_BZERO: begin
                o_cmd.op = bba_pkg::DP_BZERO;
                n_state  = bba_pkg::ST_BREAD;
            end
            bba_pkg::ST_PUSH: begin
                o_cmd.op = bba_pkg::DP_PUSH;
                n_state  = bba_pkg::ST_DONE;
            end
            bba_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = bba_pkg::DP_EMIT;
                    n_state  = bba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: dv/bba_checker.sv
`timescale 1ns / 1ps

module bba_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bba_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    bba_req_if                               i_req,
    bba_rsp_if                               i_rsp,
    output int                               o_errors,
    output int                               o_outstanding
);
    import bba_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        t_rsp_status       status;
        logic [TOT_W-1:0]  total;
    } t_alloc_rsp;

    // Mirror of the header memory and allocator bookkeeping.
    t_link             hdr_prev  [NUM_SLOTS];
    t_link             hdr_next  [NUM_SLOTS];
    t_ord              hdr_order [NUM_SLOTS];
    logic              hdr_used  [NUM_SLOTS];
    t_link             list_head [NUM_ORDERS];
    logic [21:0]       carved;
    logic [TOT_W-1:0]  used_bytes;
    logic [ADDR_W-1:0] base_reg;
    logic [HB_W-1:0]   bytes_reg;

    t_alloc_rsp        expected_rsp_q [$];

    function automatic t_slot slot_of(t_link l);
        return t_slot'(l - t_link'(1));
    endfunction

    function automatic void detach(t_slot s);
        t_link n;
        t_link p;
        n = hdr_next[s];
        p = hdr_prev[s];
        if (n != 0) hdr_prev[slot_of(n)] = p;
        if (p != 0) hdr_next[slot_of(p)] = n;
        hdr_prev[s] = '0;
        hdr_next[s] = '0;
    endfunction

    function automatic t_link pop_list(int ord);
        t_link l;
        t_slot s;
        l = list_head[ord - MIN_ORDER];
        s = slot_of(l);
        list_head[ord - MIN_ORDER] = hdr_next[s];
        detach(s);
        return l;
    endfunction

    // Finds a block of the given order, splitting larger ones or carving a new chunk.
    function automatic t_link grab_block(int ord);
        int    lv;
        t_link l;
        t_slot s;
        t_slot t;
        logic [21:0] fin;
        lv = ord;
        while (lv <= MAX_ORDER && list_head[lv - MIN_ORDER] == 0) lv++;
        if (lv > MAX_ORDER) begin
            fin = carved + (22'd1 << MAX_ORDER);
            if (fin > 22'(bytes_reg) || fin > (22'd1 << HEAP_ADDR_BITS)) return '0;
            s = t_slot'(carved >> MIN_ORDER);
            hdr_prev[s]  = '0;
            hdr_next[s]  = '0;
            hdr_order[s] = t_ord'(MAX_ORDER);
            hdr_used[s]  = 1'b0;
            list_head[NUM_ORDERS-1] = t_link'(s) + t_link'(1);
            carved = fin;
            lv = MAX_ORDER;
        end
        for (int j = lv; j > ord; j--) begin
            l = pop_list(j);
            s = slot_of(l);
            t = s + t_slot'(1 << (j - 1 - MIN_ORDER));
            hdr_prev[t]  = t_link'(s) + t_link'(1);
            hdr_next[t]  = '0;
            hdr_order[t] = t_ord'(j - 1);
            hdr_used[t]  = 1'b0;
            hdr_next[s]  = t_link'(t) + t_link'(1);
            hdr_order[s] = t_ord'(j - 1);
            list_head[j - 1 - MIN_ORDER] = t_link'(s) + t_link'(1);
        end
        return pop_list(ord);
    endfunction

    function automatic void return_block(logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] rel;
        t_slot s;
        t_slot b;
        int    ord;
        int    k;
        rel = a - ADDR_W'(HEADER_BYTES) - base_reg;
        s   = t_slot'(rel >> MIN_ORDER);
        ord = hdr_order[s];
        if (ord < MIN_ORDER || ord > MAX_ORDER) return;
        hdr_used[s] = 1'b0;
        used_bytes  = used_bytes - (TOT_W'(1) << ord);
        while (ord < MAX_ORDER) begin
            b = s ^ t_slot'(1 << (ord - MIN_ORDER));
            if (hdr_used[b] || hdr_order[b] != t_ord'(ord)) break;
            k = ord - MIN_ORDER;
            if (list_head[k] == t_link'(b) + t_link'(1)) list_head[k] = hdr_next[b];
            detach(b);
            if (b < s) s = b;
            ord++;
            hdr_order[s] = t_ord'(ord);
        end
        k = ord - MIN_ORDER;
        hdr_next[s]  = list_head[k];
        list_head[k] = t_link'(s) + t_link'(1);
        if (hdr_next[s] != 0) hdr_prev[slot_of(hdr_next[s])] = t_link'(s) + t_link'(1);
    endfunction

    function automatic t_alloc_rsp serve_request(logic rtype, logic [LEN_W-1:0] len,
                                                 logic [ADDR_W-1:0] a);
        t_alloc_rsp r;
        logic [24:0] need;
        int    ord;
        t_link l;
        r.addr   = '0;
        r.status = RS_OK;
        if (!rtype) begin
            need = 25'(len) + 25'(HEADER_BYTES);
            ord  = MIN_ORDER;
            while (ord <= MAX_ORDER && need > (25'd1 << ord)) ord++;
            if (ord > MAX_ORDER) begin
                r.status = RS_TOO_LARGE;
            end else begin
                l = grab_block(ord);
                if (l == 0) begin
                    r.status = RS_NO_MEM;
                end else begin
                    hdr_used[slot_of(l)] = 1'b1;
                    used_bytes = used_bytes + (TOT_W'(1) << ord);
                    r.addr = base_reg + (ADDR_W'(slot_of(l)) << MIN_ORDER)
                             + ADDR_W'(HEADER_BYTES);
                end
            end
        end else if (a != 0) begin
            return_block(a);
        end
        r.total = used_bytes;
        return r;
    endfunction

    t_alloc_rsp want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                hdr_prev[i]  = '0;
                hdr_next[i]  = '0;
                hdr_order[i] = '0;
                hdr_used[i]  = 1'b0;
            end
            for (int i = 0; i < NUM_ORDERS; i++) list_head[i] = '0;
            carved     = '0;
            used_bytes = '0;
            base_reg   = '0;
            bytes_reg  = '0;
            expected_rsp_q.delete();
            o_errors      = 0;
            o_outstanding = 0;
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_HEAP_BASE) base_reg = i_cfg_wdata[ADDR_W-1:0];
                else bytes_reg = i_cfg_wdata[HB_W-1:0];
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    o_errors++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_rsp.address_out !== want.addr) begin
                        $error("address_out expected %h actual %h", want.addr,
                               i_rsp.address_out);
                        o_errors++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, i_rsp.status);
                        o_errors++;
                    end
                    if (i_rsp.allocated_bytes !== want.total) begin
                        $error("allocated_bytes expected %0d actual %0d", want.total,
                               i_rsp.allocated_bytes);
                        o_errors++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                expected_rsp_q.push_back(serve_request(i_req.req_type, i_req.length,
                                                       i_req.address));
            o_outstanding = expected_rsp_q.size();
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import bba_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    errors;
    int                    outstanding;
    int                    cycles = 0;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    hold_left = 0;
    logic [ADDR_W-1:0]     base_now = '0;
    logic [ADDR_W-1:0]     live_q [$];
    logic [ADDR_W-1:0]     freed_q [$];

    bba_req_if req_ch();
    bba_rsp_if rsp_ch();

    buddy_block_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    bba_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid    = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.length   = '0;
        req_ch.address  = '0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The long hold-off is counted here so the sender can keep pushing meanwhile.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Successful allocations become candidates for later frees, kept as window offsets.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == RS_OK &&
            rsp_ch.address_out != 0)
            live_q.push_back(rsp_ch.address_out - base_now);
    end

    task automatic send_req(logic rtype, logic [LEN_W-1:0] len, logic [ADDR_W-1:0] a);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rtype;
        req_ch.length   <= len;
        req_ch.address  <= a;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_HEAP_BASE) base_now = data[ADDR_W-1:0];
    endtask

    // Frees produce no visible trailing work, so leave room for a full merge chain.
    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic free_live();
        int idx;
        logic [ADDR_W-1:0] off;
        idx = $urandom_range(live_q.size() - 1);
        off = live_q[idx];
        live_q.delete(idx);
        freed_q.push_back(off);
        if (freed_q.size() > 64) void'(freed_q.pop_front());
        send_req(1'b1, LEN_W'($urandom), base_now + off);
    endtask

    task automatic random_traffic(int count);
        int r;
        int c;
        logic [LEN_W-1:0] len;
        for (int n = 0; n < count; n++) begin
            case ((n / 40) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            r = $urandom_range(99);
            if (r < 4) begin
                send_req(1'b1, LEN_W'($urandom), '0);
            end else if (r < 7 && freed_q.size() != 0) begin
                send_req(1'b1, LEN_W'($urandom),
                         base_now + freed_q[$urandom_range(freed_q.size() - 1)]);
            end else if (r < 12) begin
                send_req(1'b0, LEN_W'($urandom_range(24'hFFFFFF, 65521)),
                         ADDR_W'($urandom));
            end else if (r < 55 || live_q.size() == 0) begin
                c = $urandom_range(9);
                if (c < 6) len = LEN_W'($urandom_range(200));
                else if (c < 9) len = LEN_W'($urandom_range(4000));
                else len = LEN_W'($urandom_range(65520));
                send_req(1'b0, len, ADDR_W'({$urandom, $urandom}));
            end else begin
                free_live();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(CFG_HEAP_BASE, '0);
        write_reg(CFG_HEAP_BYTES, '0);
        // Nothing can be carved yet: out of memory, then the too-large and free-of-zero cases.
        send_req(1'b0, '0, '0);
        send_req(1'b0, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF);
        send_req(1'b1, '0, '0);
        drain();

        write_reg(CFG_HEAP_BYTES, 48'd196608);
        send_req(1'b0, 24'd0, '0);
        send_req(1'b0, 24'd48, '0);
        send_req(1'b0, 24'd49, '0);
        send_req(1'b0, 24'd112, '0);
        send_req(1'b0, 24'd240, '0);
        send_req(1'b0, 24'd1000, '0);
        send_req(1'b0, 24'd4080, '0);
        send_req(1'b0, 24'd16000, '0);
        send_req(1'b0, 24'd65520, '0);
        send_req(1'b0, 24'd65521, '0);
        send_req(1'b0, 24'd65520, '0);
        send_req(1'b0, 24'd65520, '0);
        send_req(1'b1, '0, '0);
        drain();
        while (live_q.size() != 0) free_live();
        drain();

        random_traffic(300);
        drain();

        write_reg(CFG_HEAP_BASE, 48'hFFFF_FFFF_0000);
        write_reg(CFG_HEAP_BYTES, 48'd1048576);
        // Long receiver hold-off while requests keep coming, to back the block up.
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 400;
        for (int n = 0; n < 20; n++) send_req(1'b0, LEN_W'($urandom_range(300)), '0);
        random_traffic(450);
        drain();

        write_reg(CFG_HEAP_BASE, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_HEAP_BYTES, '0);
        random_traffic(450);
        drain();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
